@@ rtl/hpc_pkg.sv @@
// Shared types, constants and face tables for the hexahedron containment block.
`timescale 1ns / 1ps
`default_nettype none

package hpc_pkg;

  localparam int COORD_BITS_DEF = 24;   // default coordinate width
  localparam int IN_COORD_W     = 24;   // port width of a coordinate
  localparam int TOL_W          = 23;   // tolerance register width
  localparam int QUEUE_DEPTH    = 2;    // beats held between front and back
  localparam int NUM_CORNERS    = 8;
  localparam int NUM_FACES      = 6;

  localparam logic       CMD_LOAD       = 1'b0;
  localparam logic       CMD_QUERY      = 1'b1;
  localparam logic [2:0] REBUILD_CORNER = 3'd7;
  localparam logic [2:0] LAST_CORNER    = 3'd7;
  localparam logic [2:0] LAST_FACE      = 3'd5;
  localparam logic [2:0] FACE_NONE      = 3'd6;

  // Classified command that travels through the queue with the coordinates.
  typedef struct packed {
    logic       is_query;
    logic       rebuild;
    logic [2:0] vertex_index;
  } cmd_t;

  typedef struct packed {
    logic       is_query_answer;
    logic       is_inside;
    logic [2:0] failing_face;
  } result_t;

  // Corner k (a, b, c, d) of face f.
  function automatic logic [2:0] face_corner(input logic [2:0] f, input logic [1:0] k);
    logic [11:0] row;
    unique case (f)
      3'd0:    row = {3'd3, 3'd2, 3'd1, 3'd0};
      3'd1:    row = {3'd7, 3'd6, 3'd5, 3'd4};
      3'd2:    row = {3'd4, 3'd7, 3'd3, 3'd0};
      3'd3:    row = {3'd5, 3'd6, 3'd2, 3'd1};
      3'd4:    row = {3'd6, 3'd7, 3'd3, 3'd2};
      3'd5:    row = {3'd5, 3'd4, 3'd0, 3'd1};
      default: row = '0;
    endcase
    return row[k*3 +: 3];
  endfunction

  // Corner on the plane of face f used by the query.
  function automatic logic [2:0] ref_corner(input logic [2:0] f);
    logic [2:0] r;
    unique case (f)
      3'd0:    r = 3'd0;
      3'd1:    r = 3'd4;
      3'd2:    r = 3'd0;
      3'd3:    r = 3'd1;
      3'd4:    r = 3'd2;
      3'd5:    r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/hpc_queue.sv @@
// Small FIFO that decouples the front from the back.
`timescale 1ns / 1ps
`default_nettype none

module hpc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hpc_pkg::QUEUE_DEPTH   // power of two
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        mem[wr_ptr_r] <= wr_data;
        wr_ptr_r      <= AW'(wr_ptr_r + 1'b1);
      end
      if (do_rd) begin
        rd_ptr_r <= AW'(rd_ptr_r + 1'b1);
      end
      if (do_wr && !do_rd) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (do_rd && !do_wr) begin
        count_r <= CW'(count_r - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/hpc_front.sv @@
// Front end: takes input beats, classifies them and fills the command queue.
`timescale 1ns / 1ps
`default_nettype none

module hpc_front #(
  parameter int COORD_BITS = hpc_pkg::COORD_BITS_DEF
) (
  input  logic                                       push,
  input  logic                                       q_full,
  input  logic                                       in_cmd,
  input  logic [2:0]                                 in_vertex_index,
  input  logic signed [hpc_pkg::IN_COORD_W-1:0]      in_coord_x,
  input  logic signed [hpc_pkg::IN_COORD_W-1:0]      in_coord_y,
  input  logic signed [hpc_pkg::IN_COORD_W-1:0]      in_coord_z,
  output logic                                       q_wr,
  output logic [$bits(hpc_pkg::cmd_t)+3*COORD_BITS-1:0] q_wdata
);

  hpc_pkg::cmd_t cmd;

  // Only the low COORD_BITS of each coordinate carry meaning.
  always_comb begin
    cmd.is_query     = (in_cmd == hpc_pkg::CMD_QUERY);
    cmd.rebuild      = (in_cmd == hpc_pkg::CMD_LOAD) &&
                       (in_vertex_index == hpc_pkg::REBUILD_CORNER);
    cmd.vertex_index = in_vertex_index;
  end

  assign q_wr    = push && !q_full;
  assign q_wdata = {cmd, in_coord_x[COORD_BITS-1:0], in_coord_y[COORD_BITS-1:0],
                    in_coord_z[COORD_BITS-1:0]};

endmodule

`default_nettype wire

@@ rtl/hpc_mul.sv @@
// Shared signed multiplier, one 8-bit digit of the multiplier per cycle.
`timescale 1ns / 1ps
`default_nettype none

module hpc_mul #(
  parameter int MW = 103
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [MW-1:0]   a,
  input  logic signed [MW-1:0]   b,
  output logic                   done,
  output logic signed [2*MW-1:0] p
);

  localparam int ND = (MW + 7) / 8;
  localparam int LW = ND * 8;
  localparam int CW = $clog2(ND + 1);
  localparam int PW = 2 * MW;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIX} mstate_t;

  mstate_t          state_r;
  logic [MW-1:0]    mcand_r;
  logic [LW-1:0]    mplier_r;
  logic [MW-1:0]    hi_r;
  logic [LW-1:0]    lo_r;
  logic             neg_r;
  logic [CW-1:0]    cnt_r;
  logic             done_r;
  logic signed [PW-1:0] p_r;

  logic [MW-1:0]    a_mag;
  logic [MW-1:0]    b_mag;
  logic [MW+7:0]    step_sum;
  logic [MW+LW-1:0] mag;
  logic [PW-1:0]    mag_lo;

  assign a_mag    = a[MW-1] ? MW'(-a) : MW'(a);
  assign b_mag    = b[MW-1] ? MW'(-b) : MW'(b);
  assign step_sum = {8'b0, hi_r} + mcand_r * mplier_r[7:0];
  assign mag      = {hi_r, lo_r};
  assign mag_lo   = mag[PW-1:0];
  assign done     = done_r;
  assign p        = p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (start) begin
            mcand_r  <= a_mag;
            mplier_r <= LW'(b_mag);
            hi_r     <= '0;
            lo_r     <= '0;
            neg_r    <= a[MW-1] ^ b[MW-1];
            cnt_r    <= '0;
            state_r  <= M_RUN;
          end
        end
        M_RUN: begin
          hi_r     <= step_sum[MW+7:8];
          lo_r     <= {step_sum[7:0], lo_r[LW-1:8]};
          mplier_r <= mplier_r >> 8;
          cnt_r    <= CW'(cnt_r + 1'b1);
          if (cnt_r == CW'(ND - 1)) begin
            state_r <= M_FIX;
          end
        end
        M_FIX: begin
          p_r     <= neg_r ? -signed'(mag_lo) : signed'(mag_lo);
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/hpc_back.sv @@
// Back end: corner and normal stores, sequencer over the shared multiplier, result register.
`timescale 1ns / 1ps
`default_nettype none

module hpc_back #(
  parameter int COORD_BITS = hpc_pkg::COORD_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          q_valid,
  input  logic [$bits(hpc_pkg::cmd_t)+3*COORD_BITS-1:0] q_rdata,
  output logic                                          q_pop,
  input  logic [hpc_pkg::TOL_W-1:0]                     tolerance,
  input  logic                                          pop,
  output logic                                          empty,
  output hpc_pkg::result_t                              out_res
);

  localparam int C  = COORD_BITS;
  localparam int UW = C + 1;        // corner difference
  localparam int SW = C + 3;        // sum of eight corners
  localparam int WW = C + 4;        // S - 8d
  localparam int NW = 2 * C + 4;    // face normal component
  localparam int MW = 4 * C + 7;    // multiplier operand
  localparam int PW = 2 * MW;       // product and accumulator

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_LOAD, ST_LOADQ, ST_ISSUE, ST_WAIT, ST_RES
  } state_t;

  typedef enum logic [3:0] {
    SRC_UX, SRC_UY, SRC_UZ, SRC_VX, SRC_VY, SRC_VZ, SRC_WX, SRC_WY, SRC_WZ,
    SRC_NX, SRC_NY, SRC_NZ, SRC_DOT, SRC_TOL, SRC_TOL2, SRC_NN
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_NX, DST_NY, DST_NZ, DST_FLIP, DST_DOT, DST_LHS, DST_NN, DST_RHS, DST_TOL2
  } dst_t;

  // Build program: cross product, then the orientation dot product.
  // Query program: tolerance squared, then per face dot with the normal, squared distance test.
  typedef enum logic [4:0] {
    OP_B_NX0, OP_B_NX1, OP_B_NY0, OP_B_NY1, OP_B_NZ0, OP_B_NZ1, OP_B_T0, OP_B_T1, OP_B_T2,
    OP_Q_D0, OP_Q_D1, OP_Q_D2, OP_Q_SQ, OP_Q_N0, OP_Q_N1, OP_Q_N2, OP_Q_RHS, OP_Q_TOL
  } opc_t;

  typedef struct packed {
    src_t a;
    src_t b;
    logic clr;
    logic sub;
    dst_t dst;
  } op_t;

  state_t state_r;
  opc_t   op_r;
  op_t    op;

  logic signed [C-1:0]  corner_x [hpc_pkg::NUM_CORNERS];
  logic signed [C-1:0]  corner_y [hpc_pkg::NUM_CORNERS];
  logic signed [C-1:0]  corner_z [hpc_pkg::NUM_CORNERS];
  logic signed [NW-1:0] normal_x [hpc_pkg::NUM_FACES];
  logic signed [NW-1:0] normal_y [hpc_pkg::NUM_FACES];
  logic signed [NW-1:0] normal_z [hpc_pkg::NUM_FACES];

  logic signed [C-1:0]  ax_r, ay_r, az_r;
  logic signed [C-1:0]  px_r, py_r, pz_r;
  logic signed [SW-1:0] sx_r, sy_r, sz_r;
  logic signed [UW-1:0] ux_r, uy_r, uz_r;
  logic signed [UW-1:0] vx_r, vy_r, vz_r;
  logic signed [WW-1:0] wx_r, wy_r, wz_r;
  logic signed [NW-1:0] nx_r, ny_r, nz_r;
  logic signed [MW-1:0] dot_r, nn_r, tol2_r;
  logic signed [PW-1:0] lhs_r, acc_r;
  logic [2:0]           idx_r;
  logic [1:0]           ld_cnt_r;
  logic [2:0]           face_r;
  hpc_pkg::result_t     res_r;
  hpc_pkg::result_t     out_res_r;
  logic                 out_valid_r;

  hpc_pkg::cmd_t        q_cmd;
  logic signed [C-1:0]  q_x, q_y, q_z;
  logic [2:0]           cor_addr;
  logic signed [C-1:0]  cx, cy, cz;
  logic signed [MW-1:0] mul_a, mul_b;
  logic                 mul_start;
  logic                 mul_done;
  logic signed [PW-1:0] mul_p;
  logic signed [PW-1:0] acc_new;
  logic                 slot_free;

  assign q_cmd = hpc_pkg::cmd_t'(q_rdata[$bits(hpc_pkg::cmd_t)+3*C-1:3*C]);
  assign q_x   = q_rdata[3*C-1:2*C];
  assign q_y   = q_rdata[2*C-1:C];
  assign q_z   = q_rdata[C-1:0];

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign mul_start = (state_r == ST_ISSUE);
  assign slot_free = !out_valid_r || pop;
  assign empty     = !out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    unique case (state_r)
      ST_SUM:   cor_addr = idx_r;
      ST_LOADQ: cor_addr = hpc_pkg::ref_corner(face_r);
      default:  cor_addr = hpc_pkg::face_corner(face_r, ld_cnt_r);
    endcase
  end

  assign cx = corner_x[cor_addr];
  assign cy = corner_y[cor_addr];
  assign cz = corner_z[cor_addr];

  always_comb begin
    unique case (op_r)
      OP_B_NX0: op = '{SRC_UY,   SRC_VZ, 1'b1, 1'b0, DST_NONE};
      OP_B_NX1: op = '{SRC_UZ,   SRC_VY, 1'b0, 1'b1, DST_NX};
      OP_B_NY0: op = '{SRC_UZ,   SRC_VX, 1'b1, 1'b0, DST_NONE};
      OP_B_NY1: op = '{SRC_UX,   SRC_VZ, 1'b0, 1'b1, DST_NY};
      OP_B_NZ0: op = '{SRC_UX,   SRC_VY, 1'b1, 1'b0, DST_NONE};
      OP_B_NZ1: op = '{SRC_UY,   SRC_VX, 1'b0, 1'b1, DST_NZ};
      OP_B_T0:  op = '{SRC_WX,   SRC_NX, 1'b1, 1'b0, DST_NONE};
      OP_B_T1:  op = '{SRC_WY,   SRC_NY, 1'b0, 1'b0, DST_NONE};
      OP_B_T2:  op = '{SRC_WZ,   SRC_NZ, 1'b0, 1'b0, DST_FLIP};
      OP_Q_D0:  op = '{SRC_UX,   SRC_NX, 1'b1, 1'b0, DST_NONE};
      OP_Q_D1:  op = '{SRC_UY,   SRC_NY, 1'b0, 1'b0, DST_NONE};
      OP_Q_D2:  op = '{SRC_UZ,   SRC_NZ, 1'b0, 1'b0, DST_DOT};
      OP_Q_SQ:  op = '{SRC_DOT,  SRC_DOT, 1'b1, 1'b0, DST_LHS};
      OP_Q_N0:  op = '{SRC_NX,   SRC_NX, 1'b1, 1'b0, DST_NONE};
      OP_Q_N1:  op = '{SRC_NY,   SRC_NY, 1'b0, 1'b0, DST_NONE};
      OP_Q_N2:  op = '{SRC_NZ,   SRC_NZ, 1'b0, 1'b0, DST_NN};
      OP_Q_RHS: op = '{SRC_TOL2, SRC_NN, 1'b1, 1'b0, DST_RHS};
      default:  op = '{SRC_TOL,  SRC_TOL, 1'b1, 1'b0, DST_TOL2};
    endcase
  end

  function automatic logic signed [MW-1:0] pick(input src_t s);
    logic signed [MW-1:0] v;
    unique case (s)
      SRC_UX:   v = MW'(ux_r);
      SRC_UY:   v = MW'(uy_r);
      SRC_UZ:   v = MW'(uz_r);
      SRC_VX:   v = MW'(vx_r);
      SRC_VY:   v = MW'(vy_r);
      SRC_VZ:   v = MW'(vz_r);
      SRC_WX:   v = MW'(wx_r);
      SRC_WY:   v = MW'(wy_r);
      SRC_WZ:   v = MW'(wz_r);
      SRC_NX:   v = MW'(nx_r);
      SRC_NY:   v = MW'(ny_r);
      SRC_NZ:   v = MW'(nz_r);
      SRC_DOT:  v = dot_r;
      SRC_TOL:  v = signed'(MW'(tolerance));
      SRC_TOL2: v = tol2_r;
      SRC_NN:   v = nn_r;
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign mul_a   = pick(op.a);
  assign mul_b   = pick(op.b);
  assign acc_new = (op.clr ? PW'(0) : acc_r) + (op.sub ? -mul_p : mul_p);

  hpc_mul #(.MW(MW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < hpc_pkg::NUM_CORNERS; i++) begin
        corner_x[i] <= '0;
        corner_y[i] <= '0;
        corner_z[i] <= '0;
      end
      for (int i = 0; i < hpc_pkg::NUM_FACES; i++) begin
        normal_x[i] <= '0;
        normal_y[i] <= '0;
        normal_z[i] <= '0;
      end
    end else begin
      // a pop frees the result register unless ST_RES refills it this cycle
      if (pop && (state_r != ST_RES)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_cmd.is_query) begin
              px_r    <= q_x;
              py_r    <= q_y;
              pz_r    <= q_z;
              op_r    <= OP_Q_TOL;
              state_r <= ST_ISSUE;
            end else begin
              corner_x[q_cmd.vertex_index] <= q_x;
              corner_y[q_cmd.vertex_index] <= q_y;
              corner_z[q_cmd.vertex_index] <= q_z;
              res_r <= '{1'b0, 1'b0, hpc_pkg::FACE_NONE};
              if (q_cmd.rebuild) begin
                sx_r    <= '0;
                sy_r    <= '0;
                sz_r    <= '0;
                idx_r   <= '0;
                state_r <= ST_SUM;
              end else begin
                state_r <= ST_RES;
              end
            end
          end
        end
        ST_SUM: begin
          sx_r <= sx_r + SW'(cx);
          sy_r <= sy_r + SW'(cy);
          sz_r <= sz_r + SW'(cz);
          idx_r <= 3'(idx_r + 1'b1);
          if (idx_r == hpc_pkg::LAST_CORNER) begin
            face_r   <= '0;
            ld_cnt_r <= '0;
            state_r  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          unique case (ld_cnt_r)
            2'd0: begin
              ax_r <= cx;
              ay_r <= cy;
              az_r <= cz;
            end
            2'd1: begin
              ux_r <= UW'(cx) - UW'(ax_r);
              uy_r <= UW'(cy) - UW'(ay_r);
              uz_r <= UW'(cz) - UW'(az_r);
            end
            2'd2: begin
              vx_r <= UW'(cx) - UW'(ax_r);
              vy_r <= UW'(cy) - UW'(ay_r);
              vz_r <= UW'(cz) - UW'(az_r);
            end
            default: begin
              wx_r    <= WW'(sx_r) - (WW'(cx) <<< 3);
              wy_r    <= WW'(sy_r) - (WW'(cy) <<< 3);
              wz_r    <= WW'(sz_r) - (WW'(cz) <<< 3);
              op_r    <= OP_B_NX0;
              state_r <= ST_ISSUE;
            end
          endcase
          ld_cnt_r <= 2'(ld_cnt_r + 1'b1);
        end
        ST_LOADQ: begin
          ux_r    <= UW'(px_r) - UW'(cx);
          uy_r    <= UW'(py_r) - UW'(cy);
          uz_r    <= UW'(pz_r) - UW'(cz);
          nx_r    <= normal_x[face_r];
          ny_r    <= normal_y[face_r];
          nz_r    <= normal_z[face_r];
          op_r    <= OP_Q_D0;
          state_r <= ST_ISSUE;
        end
        ST_ISSUE: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_done) begin
            acc_r   <= acc_new;
            op_r    <= opc_t'(op_r + 1'b1);
            state_r <= ST_ISSUE;
            unique case (op.dst)
              DST_NX: nx_r <= NW'(acc_new);
              DST_NY: ny_r <= NW'(acc_new);
              DST_NZ: nz_r <= NW'(acc_new);
              DST_FLIP: begin
                // negative orientation test: turn the normal inward
                normal_x[face_r] <= acc_new[PW-1] ? -nx_r : nx_r;
                normal_y[face_r] <= acc_new[PW-1] ? -ny_r : ny_r;
                normal_z[face_r] <= acc_new[PW-1] ? -nz_r : nz_r;
                if (face_r == hpc_pkg::LAST_FACE) begin
                  state_r <= ST_RES;
                end else begin
                  face_r   <= 3'(face_r + 1'b1);
                  ld_cnt_r <= '0;
                  state_r  <= ST_LOAD;
                end
              end
              DST_DOT: begin
                dot_r <= MW'(acc_new);
                if (!acc_new[PW-1]) begin
                  // on or inside this face: move on
                  if (face_r == hpc_pkg::LAST_FACE) begin
                    res_r   <= '{1'b1, 1'b1, hpc_pkg::FACE_NONE};
                    state_r <= ST_RES;
                  end else begin
                    face_r  <= 3'(face_r + 1'b1);
                    state_r <= ST_LOADQ;
                  end
                end
              end
              DST_LHS: lhs_r <= acc_new;
              DST_NN:  nn_r  <= MW'(acc_new);
              DST_RHS: begin
                if (lhs_r > acc_new) begin
                  res_r   <= '{1'b1, 1'b0, face_r};
                  state_r <= ST_RES;
                end else if (face_r == hpc_pkg::LAST_FACE) begin
                  res_r   <= '{1'b1, 1'b1, hpc_pkg::FACE_NONE};
                  state_r <= ST_RES;
                end else begin
                  face_r  <= 3'(face_r + 1'b1);
                  state_r <= ST_LOADQ;
                end
              end
              DST_TOL2: begin
                tol2_r  <= MW'(acc_new);
                face_r  <= '0;
                state_r <= ST_LOADQ;
              end
              default: ;
            endcase
          end
        end
        ST_RES: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_res_r   <= res_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/hexahedron_point_containment.sv @@
// Top level of the hexahedron point containment block.
`timescale 1ns / 1ps
`default_nettype none

// Tests points against a convex eight-corner hexahedron with exact integer math.
// Input beats are loads (cmd 0: store corner vertex_index) or queries (cmd 1);
// each beat yields exactly one result beat, in order. Loading corner 7 rebuilds
// the six inward face normals from the stored corners; a query reports the first
// face whose plane the point lies outside of by more than the tolerance register.
// All work runs through one shared signed multiplier that handles 8 bits of its
// second operand per cycle. A load of corners 0..6 only stores the corner; a
// load of corner 7 also sums the eight corners and then builds the six face
// normals in turn; a query first squares the tolerance, then for each face it
// visits forms the dot product with the normal and, where the point lies on the
// outer side, the squared distance test. A two-beat queue in front keeps taking
// beats while the back is busy and the single result register waits for pop.

module hexahedron_point_containment #(
  parameter int COORD_BITS = hpc_pkg::COORD_BITS_DEF   // 12..24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  in_cmd,
  input  logic [2:0]                            in_vertex_index,
  input  logic signed [hpc_pkg::IN_COORD_W-1:0] in_coord_x,
  input  logic signed [hpc_pkg::IN_COORD_W-1:0] in_coord_y,
  input  logic signed [hpc_pkg::IN_COORD_W-1:0] in_coord_z,
  // result channel
  output logic                                  empty,
  input  logic                                  pop,
  output logic                                  out_is_query_answer,
  output logic                                  out_is_inside,
  output logic [2:0]                            out_failing_face,
  // tolerance register
  input  logic                                  cfg_wr_en,
  input  logic [hpc_pkg::TOL_W-1:0]             cfg_wr_data
);

  localparam int QW = $bits(hpc_pkg::cmd_t) + 3 * COORD_BITS;

  logic [hpc_pkg::TOL_W-1:0] tolerance_r;
  logic                      q_wr;
  logic [QW-1:0]             q_wdata;
  logic [QW-1:0]             q_rdata;
  logic                      q_full;
  logic                      q_empty;
  logic                      q_pop;
  hpc_pkg::result_t          res;

  // Tolerance: the user must write it only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r <= '0;
    end else if (cfg_wr_en) begin
      tolerance_r <= cfg_wr_data;
    end
  end

  assign full = q_full;

  // Front: classify the beat (query, plain load, load that rebuilds normals).
  hpc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .push            (push),
    .q_full          (q_full),
    .in_cmd          (in_cmd),
    .in_vertex_index (in_vertex_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .q_wr            (q_wr),
    .q_wdata         (q_wdata)
  );

  hpc_queue #(.WIDTH(QW), .DEPTH(hpc_pkg::QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back: stores, normal build and query sequencing, result register.
  hpc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .tolerance (tolerance_r),
    .pop       (pop),
    .empty     (empty),
    .out_res   (res)
  );

  assign out_is_query_answer = res.is_query_answer;
  assign out_is_inside       = res.is_inside;
  assign out_failing_face    = res.failing_face;

endmodule

`default_nettype wire

@@ rtl/hpc_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hpc_port_checks (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic       out_is_query_answer,
  input logic       out_is_inside,
  input logic [2:0] out_failing_face
);

  // Nothing waits on the result side right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result waiting after reset");

  // A load acknowledge never claims inside and names no face.
  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_is_query_answer) |->
      (!out_is_inside && out_failing_face == hpc_pkg::FACE_NONE))
    else $error("malformed load acknowledge");

  // Inside answers carry no failing face; outside answers name a real face.
  a_inside_face: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_is_query_answer) |->
      (out_is_inside == (out_failing_face == hpc_pkg::FACE_NONE)))
    else $error("inside flag and failing face disagree");

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_failing_face <= hpc_pkg::FACE_NONE))
    else $error("failing face out of range");

  // A result not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_failing_face) && $stable(out_is_inside)))
    else $error("waiting result changed");

endmodule

bind hexahedron_point_containment hpc_port_checks u_hpc_port_checks (
  .clk                 (clk),
  .rst_n               (rst_n),
  .empty               (empty),
  .pop                 (pop),
  .out_is_query_answer (out_is_query_answer),
  .out_is_inside       (out_is_inside),
  .out_failing_face    (out_failing_face)
);

`default_nettype wire

@@ verif/hpc_checker.sv @@
// Beat monitor, containment predictor and result comparator for the hexahedron block.
`timescale 1ns / 1ps

module hpc_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  input  logic                                  full,
  input  logic                                  in_cmd,
  input  logic [2:0]                            in_vertex_index,
  input  logic signed [hpc_pkg::IN_COORD_W-1:0] in_coord_x,
  input  logic signed [hpc_pkg::IN_COORD_W-1:0] in_coord_y,
  input  logic signed [hpc_pkg::IN_COORD_W-1:0] in_coord_z,
  input  logic                                  empty,
  input  logic                                  pop,
  input  logic                                  out_is_query_answer,
  input  logic                                  out_is_inside,
  input  logic [2:0]                            out_failing_face,
  input  logic                                  cfg_wr_en,
  input  logic [hpc_pkg::TOL_W-1:0]             cfg_wr_data,
  output int                                    n_pending,
  output int                                    n_errors
);

  typedef logic signed [255:0] wide_t;

  // face corners a, b, c, d and the query reference corner
  localparam int FACE_A [6] = '{0, 4, 0, 1, 2, 1};
  localparam int FACE_B [6] = '{1, 5, 3, 2, 3, 0};
  localparam int FACE_C [6] = '{2, 6, 7, 6, 7, 4};
  localparam int FACE_D [6] = '{3, 7, 4, 5, 6, 5};
  localparam int REF_CORNER [6] = '{0, 4, 0, 1, 2, 1};

  wide_t cx [8], cy [8], cz [8];
  wide_t nx [6], ny [6], nz [6];
  logic [hpc_pkg::TOL_W-1:0] tol_reg;
  hpc_pkg::result_t answers_q [$];

  task automatic build_inward_normals();
    wide_t sx, sy, sz, ux, uy, uz, vx, vy, vz, tx, ty, tz, t;
    wide_t mx, my, mz;
    sx = 0; sy = 0; sz = 0;
    for (int k = 0; k < 8; k++) begin
      sx = sx + cx[k]; sy = sy + cy[k]; sz = sz + cz[k];
    end
    for (int f = 0; f < 6; f++) begin
      ux = cx[FACE_B[f]] - cx[FACE_A[f]];
      uy = cy[FACE_B[f]] - cy[FACE_A[f]];
      uz = cz[FACE_B[f]] - cz[FACE_A[f]];
      vx = cx[FACE_C[f]] - cx[FACE_A[f]];
      vy = cy[FACE_C[f]] - cy[FACE_A[f]];
      vz = cz[FACE_C[f]] - cz[FACE_A[f]];
      mx = uy * vz - uz * vy;
      my = uz * vx - ux * vz;
      mz = ux * vy - uy * vx;
      tx = sx - (cx[FACE_D[f]] <<< 3);
      ty = sy - (cy[FACE_D[f]] <<< 3);
      tz = sz - (cz[FACE_D[f]] <<< 3);
      t = tx * mx + ty * my + tz * mz;
      // flip only on a strictly negative test, zero keeps the sign
      if (t < 0) begin
        mx = -mx; my = -my; mz = -mz;
      end
      nx[f] = mx; ny[f] = my; nz[f] = mz;
    end
  endtask

  function automatic hpc_pkg::result_t classify_point(wide_t px, wide_t py, wide_t pz);
    hpc_pkg::result_t r;
    wide_t tolw, tol2, dot, len2;
    int rc;
    tolw = tol_reg;
    tol2 = tolw * tolw;
    r.is_query_answer = 1'b1;
    r.is_inside = 1'b1;
    r.failing_face = hpc_pkg::FACE_NONE;
    for (int f = 0; f < 6; f++) begin
      rc = REF_CORNER[f];
      dot = (px - cx[rc]) * nx[f] + (py - cy[rc]) * ny[f] + (pz - cz[rc]) * nz[f];
      len2 = nx[f] * nx[f] + ny[f] * ny[f] + nz[f] * nz[f];
      if (r.is_inside && dot < 0 && dot * dot > tol2 * len2) begin
        r.is_inside = 1'b0;
        r.failing_face = f[2:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  initial n_errors = 0;

  always @(posedge clk) begin
    hpc_pkg::result_t want, ack;
    wide_t px, py, pz;
    if (!rst_n) begin
      for (int k = 0; k < 8; k++) begin
        cx[k] = 0; cy[k] = 0; cz[k] = 0;
      end
      for (int f = 0; f < 6; f++) begin
        nx[f] = 0; ny[f] = 0; nz[f] = 0;
      end
      tol_reg = '0;
      answers_q.delete();
    end else begin
      if (cfg_wr_en) tol_reg = cfg_wr_data;
      if (push && !full) begin
        px = in_coord_x; py = in_coord_y; pz = in_coord_z;
        if (in_cmd == hpc_pkg::CMD_LOAD) begin
          cx[in_vertex_index] = px; cy[in_vertex_index] = py; cz[in_vertex_index] = pz;
          if (in_vertex_index == hpc_pkg::REBUILD_CORNER) build_inward_normals();
          ack.is_query_answer = 1'b0;
          ack.is_inside = 1'b0;
          ack.failing_face = hpc_pkg::FACE_NONE;
        end else begin
          ack = classify_point(px, py, pz);
        end
        answers_q = {answers_q, ack};
      end
      if (pop && !empty) begin
        if (answers_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = answers_q.pop_front();
          if (out_is_query_answer !== want.is_query_answer)
            report_mismatch("is_query_answer", out_is_query_answer, want.is_query_answer);
          if (out_is_inside !== want.is_inside)
            report_mismatch("is_inside", out_is_inside, want.is_inside);
          if (out_failing_face !== want.failing_face)
            report_mismatch("failing_face", out_failing_face, want.failing_face);
        end
      end
    end
    n_pending <= answers_q.size();
  end

endmodule

@@ verif/hexahedron_point_containment_tb.sv @@
// Stimulus, idling control and verdict for the hexahedron containment testbench.
`timescale 1ns / 1ps

module hexahedron_point_containment_tb;
  import hpc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full, empty;
  logic in_cmd = 1'b0;
  logic [2:0] in_vertex_index = '0;
  logic signed [IN_COORD_W-1:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic pop = 1'b0;
  logic out_is_query_answer, out_is_inside;
  logic [2:0] out_failing_face;
  logic cfg_wr_en = 1'b0;
  logic [TOL_W-1:0] cfg_wr_data = '0;
  int n_pending, n_errors;

  // idle / stall rates in percent, changed per phase
  int send_idle_pct = 0;
  int pop_stall_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hexahedron_point_containment i_dut (
    .clk, .rst_n, .push, .full, .in_cmd, .in_vertex_index,
    .in_coord_x, .in_coord_y, .in_coord_z, .empty, .pop,
    .out_is_query_answer, .out_is_inside, .out_failing_face,
    .cfg_wr_en, .cfg_wr_data
  );

  hpc_checker i_checker (
    .clk, .rst_n, .push, .full, .in_cmd, .in_vertex_index,
    .in_coord_x, .in_coord_y, .in_coord_z, .empty, .pop,
    .out_is_query_answer, .out_is_inside, .out_failing_face,
    .cfg_wr_en, .cfg_wr_data, .n_pending, .n_errors
  );

  // Receiver: stall pop at the phase's rate.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Clamp a longint to the signed 24-bit coordinate range.
  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  // One beat on the input channel; idles first at the current rate.
  task automatic send_beat(logic cmd, logic [2:0] idx, logic signed [23:0] x,
                           logic signed [23:0] y, logic signed [23:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_cmd <= cmd;
    in_vertex_index <= idx;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    do @(posedge clk); while (full);
  endtask

  // Stop sending and wait until every expected beat has come back.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Axis-aligned box: corners 0..3 at low z, 4..7 at high z, matching the face table.
  task automatic load_box(longint cx, longint cy, longint cz, longint hx, longint hy,
                          longint hz, int jit);
    longint sxs [8] = '{-1, 1, 1, -1, -1, 1, 1, -1};
    longint sys [8] = '{-1, -1, 1, 1, -1, -1, 1, 1};
    longint szs [8] = '{-1, -1, -1, -1, 1, 1, 1, 1};
    for (int k = 0; k < 8; k++) begin
      send_beat(CMD_LOAD, k[2:0],
                clamp24(cx + sxs[k] * hx + $signed($urandom_range(2 * jit)) - jit),
                clamp24(cy + sys[k] * hy + $signed($urandom_range(2 * jit)) - jit),
                clamp24(cz + szs[k] * hz + $signed($urandom_range(2 * jit)) - jit));
    end
  endtask

  int items_sent;

  // A well-formed set: a fresh hexahedron, then queries around it. Some sets are noise.
  task automatic random_set();
    longint cx, cy, cz, hx, hy, hz, ox, oy, oz;
    int nq, kind;
    cx = $signed($urandom_range(1 << 22)) - (1 << 21);
    cy = $signed($urandom_range(1 << 22)) - (1 << 21);
    cz = $signed($urandom_range(1 << 22)) - (1 << 21);
    hx = $urandom_range(1, ($urandom_range(3) == 0) ? 64 : (1 << 19));
    hy = $urandom_range(1, ($urandom_range(3) == 0) ? 64 : (1 << 19));
    hz = $urandom_range(1, ($urandom_range(3) == 0) ? 64 : (1 << 19));
    if ($urandom_range(7) == 0) begin
      // random corners in random order, often a non-convex mess
      for (int k = 0; k < 8; k++)
        send_beat(CMD_LOAD, (k == 7) ? REBUILD_CORNER : 3'($urandom_range(6)),
                  24'($urandom), 24'($urandom), 24'($urandom));
    end else begin
      load_box(cx, cy, cz, hx, hy, hz, int'(hx < hy ? hx : hy) / 8);
    end
    items_sent += 8;
    nq = $urandom_range(4, 14);
    for (int q = 0; q < nq; q++) begin
      kind = $urandom_range(9);
      ox = $signed($urandom_range(3 * hx)) - (3 * hx) / 2;
      oy = $signed($urandom_range(3 * hy)) - (3 * hy) / 2;
      oz = $signed($urandom_range(3 * hz)) - (3 * hz) / 2;
      if (kind == 0)
        send_beat(CMD_QUERY, 3'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
      else if (kind == 1)
        send_beat(CMD_QUERY, 3'($urandom), clamp24(cx + hx), clamp24(cy - hy),
                  clamp24(cz + hz));
      else if (kind == 2 && q != 0)
        // stray corner rewrite below 7: normals must stay
        send_beat(CMD_LOAD, 3'($urandom_range(6)), 24'($urandom), 24'($urandom),
                  24'($urandom));
      else
        send_beat(CMD_QUERY, 3'($urandom), clamp24(cx + ox), clamp24(cy + oy),
                  clamp24(cz + oz));
      items_sent++;
    end
  endtask

  initial begin
    logic [TOL_W-1:0] tol_sel [5];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // no normals yet: every query is inside
    send_beat(CMD_QUERY, 3'd0, 24'sh7FFFFF, -24'sd8388608, 24'sd0);
    // corners below 7 only, normals stay zero
    send_beat(CMD_LOAD, 3'd0, -24'sd8388608, -24'sd8388608, -24'sd8388608);
    send_beat(CMD_QUERY, 3'd7, -24'sd8388608, 24'sh7FFFFF, 24'sh7FFFFF);
    // extreme box over the whole coordinate range
    load_box(0, 0, 0, 8388608, 8388608, 8388608, 0);
    send_beat(CMD_QUERY, 3'd2, 24'sd0, 24'sd0, 24'sd0);
    send_beat(CMD_QUERY, 3'd5, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_beat(CMD_QUERY, 3'd1, -24'sd8388608, -24'sd8388608, -24'sd8388608);
    drain();
    write_tolerance('0);
    // unit box of side 2048 around the origin; one point past each face, one on a plane
    load_box(0, 0, 0, 1024, 1024, 1024, 0);
    send_beat(CMD_QUERY, 3'd0, 24'sd0, 24'sd0, -24'sd1100);
    send_beat(CMD_QUERY, 3'd0, 24'sd0, 24'sd0, 24'sd1100);
    send_beat(CMD_QUERY, 3'd0, -24'sd1100, 24'sd0, 24'sd0);
    send_beat(CMD_QUERY, 3'd0, 24'sd1100, 24'sd0, 24'sd0);
    send_beat(CMD_QUERY, 3'd0, 24'sd0, 24'sd1100, 24'sd0);
    send_beat(CMD_QUERY, 3'd0, 24'sd0, -24'sd1100, 24'sd0);
    send_beat(CMD_QUERY, 3'd0, 24'sd1024, 24'sd0, 24'sd0);
    drain();
    // the same outside point is accepted once the tolerance covers it
    write_tolerance(TOL_W'(100));
    send_beat(CMD_QUERY, 3'd0, 24'sd1100, 24'sd0, 24'sd0);
    send_beat(CMD_QUERY, 3'd0, 24'sd1125, 24'sd0, 24'sd0);
    // flat body in z = 0: faces 0 and 1 keep their unflipped normals
    load_box(0, 0, 0, 512, 512, 0, 0);
    send_beat(CMD_QUERY, 3'd0, 24'sd0, 24'sd0, 24'sd300);
    // all corners equal: every face degenerate
    for (int k = 0; k < 8; k++) send_beat(CMD_LOAD, k[2:0], 24'sd77, -24'sd5, 24'sd9);
    send_beat(CMD_QUERY, 3'd0, -24'sd8388608, 24'sh7FFFFF, 24'sd0);
    drain();

    // --- random part, phases of idling and tolerance ---
    tol_sel = '{TOL_W'(0), TOL_W'(8388607), TOL_W'($urandom_range(64)),
                TOL_W'($urandom), TOL_W'(16)};
    items_sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 82; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 82; end
        3: begin send_idle_pct = 25; pop_stall_pct = 25; end
        default: begin send_idle_pct = 0; pop_stall_pct = 0; end
      endcase
      write_tolerance(tol_sel[ph]);
      while (items_sent < (ph + 1) * 190) begin
        random_set();
        // once in a while the sender holds off until everything is back
        if ($urandom_range(5) == 0) drain();
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (n_errors == 0 && n_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung block.
  initial begin
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ hexahedron_point_containment.f @@
rtl/hpc_pkg.sv
rtl/hpc_queue.sv
rtl/hpc_front.sv
rtl/hpc_mul.sv
rtl/hpc_back.sv
rtl/hexahedron_point_containment.sv
rtl/hpc_checker.sv
verif/hpc_checker.sv
verif/hexahedron_point_containment_tb.sv
